[rtl/cau_pkg.sv]
// Shared types, constants and arithmetic helpers of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_SHIFT = 32 - FRAC_BITS;
    localparam int DIV_STEPS = 32;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [1:0] KIND_DIRECT = 2'd0;
    localparam logic [1:0] KIND_DIV    = 2'd1;
    localparam logic [1:0] KIND_DIVZ   = 2'd2;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic              is_div;
        logic [1:0]        op;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } cau_item_t;

    typedef struct packed {
        logic        neg;
        logic        sat;
        logic [63:0] rem;
        logic [31:0] sh;
    } cau_part_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] den;
        cau_part_t   re;
        cau_part_t   im;
    } cau_pipe_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } cau_sat_t;

    function automatic cau_sat_t sat32(logic signed [64:0] v);
        cau_sat_t r;
        if ((&v[64:31]) || !(|v[64:31]))
        begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        else
        begin
            r.val = v[64] ? SAT_MIN : SAT_MAX;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    // Sets up one part: direct results are saturated here, a quotient gets
    // its sign, overflow test, starting remainder and low dividend bits.
    function automatic cau_part_t prep_part(logic [1:0] op, logic signed [64:0] s,
                                            logic [63:0] den);
        cau_part_t         p;
        cau_sat_t          r;
        logic [63:0]       mag;
        logic [63:0]       hi;
        logic signed [64:0] sh;
        p   = '0;
        mag = s[64] ? 64'(-s) : s[63:0];
        hi  = mag >> DIV_SHIFT;
        sh  = s >>> FRAC_BITS;
        case (op)
            OP_ADD, OP_SUB:
            begin
                r     = sat32(s);
                p.sh  = r.val;
                p.sat = r.sat;
            end
            OP_MUL:
            begin
                r     = sat32(sh);
                p.sh  = r.val;
                p.sat = r.sat;
            end
            default:
            begin
                p.neg = s[64];
                p.sat = (hi >= den);
                p.rem = hi;
                p.sh  = mag[31:0] << FRAC_BITS;
            end
        endcase
        return p;
    endfunction

    // One restoring division step: the top dividend bit moves into the
    // remainder and the new quotient bit enters at the bottom.
    function automatic cau_part_t div_step(cau_part_t p, logic [63:0] den);
        cau_part_t  r;
        logic [64:0] t;
        logic        ge;
        r     = p;
        t     = {p.rem, p.sh[31]};
        ge    = (t >= {1'b0, den});
        r.rem = ge ? 64'(t - {1'b0, den}) : t[63:0];
        r.sh  = {p.sh[30:0], ge};
        return r;
    endfunction

    function automatic cau_sat_t fin_part(cau_part_t p, logic [1:0] kind);
        cau_sat_t r;
        r = '0;
        case (kind)
            KIND_DIRECT:
            begin
                r.val = p.sh;
                r.sat = p.sat;
            end
            KIND_DIV:
            begin
                if (p.sat)
                begin
                    r.val = p.neg ? SAT_MIN : SAT_MAX;
                    r.sat = 1'b1;
                end
                else if (p.neg)
                begin
                    if (p.sh > SAT_MIN)
                    begin
                        r.val = SAT_MIN;
                        r.sat = 1'b1;
                    end
                    else
                    begin
                        r.val = 32'(-p.sh);
                    end
                end
                else if (p.sh[31])
                begin
                    r.val = SAT_MAX;
                    r.sat = 1'b1;
                end
                else
                begin
                    r.val = p.sh;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: front queue and back pipeline.
// An accepted request passes the queue, three arithmetic stages, 32 division
// steps and the result register. Throughput: one request per cycle for every
// operation while the output is not stalled; all requests pass the 32-stage
// restoring divider, which is pipelined.
// Reset (rst_n, asynchronous, active low) empties the queue and the pipeline.
`default_nettype none
module complex_arithmetic_unit import cau_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // a_real, a_imag, b_real, b_imag from bit 0 up
    input  wire logic [1:0]   s_tuser,  // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,  // res_real, res_imag from bit 0 up
    output logic [1:0]        m_tuser   // status
);

    // The two-entry front queue lets requests arrive while the output is
    // stalled, until it is full; the back end advances as one whenever the result
    // register is free or being taken.
    logic      q_valid;
    logic      q_pop;
    cau_item_t q_item;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Products, sums, divide set-up, the divider chain and the result
    // register. Division saturates early when the quotient cannot fit.
    cau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_SAT || m_tuser == ST_DIVZ))
        else $error("invalid status code");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_DIVZ) |-> (m_tdata == 64'd0))
        else $error("division by zero gave a nonzero result");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_SAT) |->
            (m_tdata[31:0] == SAT_MAX || m_tdata[31:0] == SAT_MIN ||
             m_tdata[63:32] == SAT_MAX || m_tdata[63:32] == SAT_MIN))
        else $error("saturation status without a limit value");
`endif

endmodule
`default_nettype wire

[rtl/cau_front.sv]
// Front end: accepts requests into a short queue and classifies them.
`default_nettype none
module cau_front import cau_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // a_real, a_imag, b_real, b_imag
    input  wire logic [1:0]   s_tuser,  // op
    output logic              q_valid,
    output cau_item_t         q_item,
    input  wire logic         q_pop
);

    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    cau_item_t  mem_reg [QDEPTH];
    cau_item_t  in_item;
    logic       push;
    logic       pop;

    always_comb
    begin
        in_item.op     = s_tuser;
        in_item.is_div = (s_tuser == OP_DIV);
        in_item.a_real = s_tdata[31:0];
        in_item.a_imag = s_tdata[63:32];
        in_item.b_real = s_tdata[95:64];
        in_item.b_imag = s_tdata[127:96];
    end

    assign s_tready = (count_reg != 2'(QDEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule
`default_nettype wire

[rtl/cau_div_step.sv]
// One registered restoring division step for both result parts.
`default_nettype none
module cau_div_step import cau_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  cau_pipe_t in_data,
    output logic      out_valid,
    output cau_pipe_t out_data
);

    cau_pipe_t data_next;

    always_comb
    begin
        data_next = in_data;
        if (in_data.kind == KIND_DIV)
        begin
            data_next.re = div_step(in_data.re, in_data.den);
            data_next.im = div_step(in_data.im, in_data.den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data <= data_next;
    end

endmodule
`default_nettype wire

[rtl/cau_back.sv]
// Back end: product, sum and set-up stages, division chain and result register.
`default_nettype none
module cau_back import cau_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  cau_item_t        q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,  // res_real, res_imag
    output logic [1:0]       m_tuser   // status
);

    logic adv;

    // Stage A: products and direct sums.
    logic               a_valid_reg;
    logic [1:0]         a_op_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_br_reg, p_bi_reg;
    logic signed [32:0] as_re_reg, as_im_reg;

    // Stage B: wide sums and squared divisor magnitude.
    logic               b_valid_reg;
    logic [1:0]         b_op_reg;
    logic signed [64:0] sum_re_reg, sum_im_reg;
    logic signed [64:0] sum_re_next, sum_im_next;
    logic [63:0]        den_reg;

    // Stage C and the division chain.
    logic      stg_valid [DIV_STEPS + 1];
    cau_pipe_t stg_data  [DIV_STEPS + 1];
    cau_pipe_t c_next;

    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic [1:0]  m_user_reg;
    cau_sat_t    fin_re, fin_im;

    assign adv   = !m_valid_reg || m_tready;
    assign q_pop = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            stg_valid[0] <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg  <= q_valid;
            b_valid_reg  <= a_valid_reg;
            stg_valid[0] <= b_valid_reg;
            m_valid_reg  <= stg_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg  <= q_item.op;
            p_rr_reg  <= 64'(q_item.a_real) * 64'(q_item.b_real);
            p_ii_reg  <= 64'(q_item.a_imag) * 64'(q_item.b_imag);
            p_ri_reg  <= 64'(q_item.a_real) * 64'(q_item.b_imag);
            p_ir_reg  <= 64'(q_item.a_imag) * 64'(q_item.b_real);
            p_br_reg  <= q_item.is_div ? 64'(q_item.b_real) * 64'(q_item.b_real) : 64'sd0;
            p_bi_reg  <= q_item.is_div ? 64'(q_item.b_imag) * 64'(q_item.b_imag) : 64'sd0;
            as_re_reg <= (q_item.op == OP_SUB)
                         ? 33'(q_item.a_real) - 33'(q_item.b_real)
                         : 33'(q_item.a_real) + 33'(q_item.b_real);
            as_im_reg <= (q_item.op == OP_SUB)
                         ? 33'(q_item.a_imag) - 33'(q_item.b_imag)
                         : 33'(q_item.a_imag) + 33'(q_item.b_imag);
        end
    end

    always_comb
    begin
        case (a_op_reg)
            OP_ADD, OP_SUB:
            begin
                sum_re_next = {{32{as_re_reg[32]}}, as_re_reg};
                sum_im_next = {{32{as_im_reg[32]}}, as_im_reg};
            end
            OP_MUL:
            begin
                sum_re_next = {p_rr_reg[63], p_rr_reg} - {p_ii_reg[63], p_ii_reg};
                sum_im_next = {p_ri_reg[63], p_ri_reg} + {p_ir_reg[63], p_ir_reg};
            end
            default:
            begin
                sum_re_next = {p_rr_reg[63], p_rr_reg} + {p_ii_reg[63], p_ii_reg};
                sum_im_next = {p_ir_reg[63], p_ir_reg} - {p_ri_reg[63], p_ri_reg};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_op_reg   <= a_op_reg;
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
            den_reg    <= p_br_reg + p_bi_reg;
        end
    end

    always_comb
    begin
        c_next.den = den_reg;
        if (b_op_reg != OP_DIV)
            c_next.kind = KIND_DIRECT;
        else if (den_reg == 64'd0)
            c_next.kind = KIND_DIVZ;
        else
            c_next.kind = KIND_DIV;
        c_next.re = prep_part(b_op_reg, sum_re_reg, den_reg);
        c_next.im = prep_part(b_op_reg, sum_im_reg, den_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stg_data[0] <= c_next;
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        cau_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (stg_valid[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i + 1]),
            .out_data  (stg_data[i + 1])
        );
    end

    assign fin_re = fin_part(stg_data[DIV_STEPS].re, stg_data[DIV_STEPS].kind);
    assign fin_im = fin_part(stg_data[DIV_STEPS].im, stg_data[DIV_STEPS].kind);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= {fin_im.val, fin_re.val};
            if (stg_data[DIV_STEPS].kind == KIND_DIVZ)
                m_user_reg <= ST_DIVZ;
            else if (fin_re.sat || fin_im.sat)
                m_user_reg <= ST_SAT;
            else
                m_user_reg <= ST_OK;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

[test/tb_complex_arithmetic_unit.sv]
// Testbench of the complex arithmetic unit: random and directed requests checked against a predictor.
`default_nettype none
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    // One request as it is driven on the slave side.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } cplx_req_t;

    // One result as it is seen on the master side.
    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic [1:0]         status;
    } cplx_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    cplx_req_t pending_reqs[$];
    cplx_res_t expected_results[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_sender;
    bit        in_taken;
    int        err_count;
    int        res_count;
    int        cycle_count;
    int        op_seen[4];
    int        sat_seen;
    int        divz_seen;

    complex_arithmetic_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Clamps a wide value to the signed 32-bit range and flags saturation.
    function automatic logic [31:0] clamp32(logic signed [127:0] v, inout bit sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Quotient of (num << FRAC_BITS) by den, truncated towards zero.
    function automatic logic signed [127:0] scaled_quot(logic signed [127:0] num,
                                                        logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = num[127] ? 128'(-num) : num;
        q   = (mag << FRAC_BITS) / den;
        return num[127] ? 128'(-q) : q;
    endfunction

    // Works out the complex result and status that a request must produce.
    function automatic cplx_res_t complex_result(cplx_req_t r);
        cplx_res_t           res;
        logic signed [127:0] ar;
        logic signed [127:0] ai;
        logic signed [127:0] br;
        logic signed [127:0] bi;
        logic signed [127:0] re;
        logic signed [127:0] im;
        logic [127:0]        den;
        bit                  sat;
        ar  = r.a_real;
        ai  = r.a_imag;
        br  = r.b_real;
        bi  = r.b_imag;
        sat = 1'b0;
        res = '0;
        case (r.op)
            OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL:
            begin
                re = (ar * br - ai * bi) >>> FRAC_BITS;
                im = (ar * bi + ai * br) >>> FRAC_BITS;
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    res.status = ST_DIVZ;
                    return res;
                end
                re = scaled_quot(ar * br + ai * bi, den);
                im = scaled_quot(ai * br - ar * bi, den);
            end
        endcase
        res.res_real = clamp32(re, sat);
        res.res_imag = clamp32(im, sat);
        res.status   = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    // Random operand part: half shifted short values, some extremes, some zeros, some full range.
    function automatic logic [31:0] rand_part();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return 32'h0;
            2, 3, 4: return $urandom;
            default: return 32'($signed(17'($urandom))) <<< $urandom_range(0, 15);
        endcase
    endfunction

    task automatic queue_req(logic [1:0] op, logic [31:0] ar, logic [31:0] ai,
                             logic [31:0] br, logic [31:0] bi);
        cplx_req_t r;
        r.op     = op;
        r.a_real = ar;
        r.a_imag = ai;
        r.b_real = br;
        r.b_imag = bi;
        pending_reqs.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", res_count, what, got, want);
        err_count++;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Driver: requests change at the falling edge; valid stays up across
    // back-to-back requests so it is never lowered and raised in one step.
    // Whether the current request was taken is decided at the rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_taken)
            begin
                // Hold the current request until it is taken.
            end
            else if (!hold_sender && pending_reqs.size() != 0 &&
                     $urandom_range(0, 99) >= send_idle_pct)
            begin
                cplx_req_t r;
                r        = pending_reqs.pop_front();
                s_tdata  <= {r.b_imag, r.b_real, r.a_imag, r.a_real};
                s_tuser  <= r.op;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: accepted requests feed the predictor, accepted results are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            in_taken    <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                cplx_req_t r;
                r = {s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]};
                expected_results.push_back(complex_result(r));
                op_seen[r.op]++;
            end
            if (m_tvalid && m_tready)
            begin
                cplx_res_t want;
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result %h status %0d", m_tdata, m_tuser);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.res_real)
                        report_mismatch("res_real", m_tdata[31:0], want.res_real);
                    if (m_tdata[63:32] !== want.res_imag)
                        report_mismatch("res_imag", m_tdata[63:32], want.res_imag);
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (want.status == ST_SAT)
                        sat_seen++;
                    if (want.status == ST_DIVZ)
                        divz_seen++;
                end
                res_count++;
            end
            if (cycle_count > 400000)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] mx;
        logic [31:0] mn;
        mx            = 32'h7FFF_FFFF;
        mn            = 32'h8000_0000;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_ADD;
        m_tready      = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 61;
        hold_sender   = 1'b0;
        in_taken      = 1'b0;
        err_count     = 0;
        res_count     = 0;
        cycle_count   = 0;
        sat_seen      = 0;
        divz_seen     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: extremes, every operation, saturation both ways,
        // division by zero and by a tiny divisor, and exact-range quotients.
        queue_req(OP_ADD, mx, mn, mx, mn);
        queue_req(OP_ADD, mx, mn, mn, mx);
        queue_req(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0);
        queue_req(OP_SUB, mx, mn, mn, mx);
        queue_req(OP_SUB, mn, mx, 32'h1, 32'hFFFF_FFFF);
        queue_req(OP_SUB, 32'h0, 32'h0, mn, mn);
        queue_req(OP_MUL, mn, mn, mn, mn);
        queue_req(OP_MUL, mx, mx, mx, mn);
        queue_req(OP_MUL, 32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h1);
        queue_req(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0004_0000);
        queue_req(OP_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        queue_req(OP_DIV, mx, mn, 32'h0, 32'h0);
        queue_req(OP_DIV, mx, mx, 32'h1, 32'h0);
        queue_req(OP_DIV, mn, mn, 32'h0, 32'h1);
        queue_req(OP_DIV, 32'h0006_0000, 32'h0, 32'h0002_0000, 32'h0);
        queue_req(OP_DIV, 32'hFFFF_FFFF, 32'h1, 32'h0003_0000, 32'hFFFD_0000);
        queue_req(OP_DIV, mn, 32'h0, 32'hFFFF_0000, 32'h0);
        queue_req(OP_DIV, mx, mx, mx, mx);
        queue_req(OP_DIV, mn, mn, mn, mn);
        queue_req(OP_DIV, 32'h8000, 32'h0, 32'h0001_0000, 32'h0);
        queue_req(OP_DIV, 32'h0, 32'h0, mn, mx);

        // Random part in three stretches of idling, with a full drain in between.
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int k = 0; k < 180; k++)
                queue_req(2'($urandom_range(0, 3)), rand_part(), rand_part(),
                          $urandom_range(0, 15) == 0 ? 32'h0 : rand_part(),
                          $urandom_range(0, 15) == 0 ? 32'h0 : rand_part());
            if (phase == 2)
            begin
                // Stop sending part-way and let every outstanding result come back.
                repeat (60) @(posedge clk);
                hold_sender = 1'b1;
                while (expected_results.size() != 0 || s_tvalid)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            wait_drained();
            if (phase == 0)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        wait_drained();
        repeat (60) @(posedge clk);

        $display("%0d results checked: add %0d, sub %0d, mul %0d, div %0d requests",
                 res_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("%0d saturated and %0d divide-by-zero results among them", sat_seen, divz_seen);
        if (err_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[complex_arithmetic_unit.f]
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
test/tb_complex_arithmetic_unit.sv
